/* rtl/wgm_pkg.sv */
// ----------------------------------------------------------------------------
// Glob match package
// Shared constants, codes, types and the case-folding helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wgm_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int NAME_MAX_DEF    = 256;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_CASE  = 8'h20;

  typedef enum logic [1:0] {
    OP_PAT_CHAR   = 2'd0,
    OP_NAME_CHAR  = 2'd1,
    OP_EMPTY_NAME = 2'd2,
    OP_EMPTY_PAT  = 2'd3
  } op_t;

  typedef struct packed {
    logic start;
    logic over;
    logic fold;
  } walk_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic matched;
    logic too_long;
  } walk_sts_t;

  function automatic logic [7:0] fold_ch(input logic en, input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (en && c >= CH_UP_A && c <= CH_UP_Z) r = c | CH_CASE;
    return r;
  endfunction

endpackage

/* rtl/wgm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/wgm_walk.sv */
// ----------------------------------------------------------------------------
// Glob walk sequencer
// Greedy single-star backtracking walk, one step per cycle over both stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgm_walk #(
  parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF,
  parameter int NAME_MAX    = wgm_pkg::NAME_MAX_DEF,
  parameter int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
  parameter int NAW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1,
  parameter int PLW = $clog2(PATTERN_MAX + 1),
  parameter int NLW = $clog2(NAME_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wgm_pkg::walk_req_t  req,
  input  logic [PLW-1:0]      plen,
  input  logic [NLW-1:0]      nlen,
  input  logic [7:0]          pat_rdata,
  input  logic [7:0]          name_rdata,
  output logic [PAW-1:0]      pat_raddr,
  output logic [NAW-1:0]      name_raddr,
  output wgm_pkg::walk_sts_t  sts
);
  import wgm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_START = 3'b010,
    ST_WALK  = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  logic [PLW-1:0] p_r, p_nxt, star_r, star_nxt;
  logic [NLW-1:0] f_r, f_nxt, mark_r, mark_nxt, nlen_r, nlen_nxt;
  logic           have_r, have_nxt, over_r, over_nxt, fold_r, fold_nxt;
  logic           done, matched;
  logic           p_in, is_star, is_hit;

  assign p_in    = p_r < plen;
  assign is_star = p_in && pat_rdata == CH_STAR;
  assign is_hit  = p_in && (pat_rdata == CH_QUEST ||
                   fold_ch(fold_r, pat_rdata) == fold_ch(fold_r, name_rdata));

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    f_nxt     = f_r;
    star_nxt  = star_r;
    mark_nxt  = mark_r;
    have_nxt  = have_r;
    nlen_nxt  = nlen_r;
    over_nxt  = over_r;
    fold_nxt  = fold_r;
    done      = 1'b0;
    matched   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          nlen_nxt  = nlen;
          over_nxt  = req.over;
          fold_nxt  = req.fold;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        p_nxt    = '0;
        f_nxt    = '0;
        have_nxt = 1'b0;
        if (over_r) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (f_r < nlen_r) begin
          if (is_star) begin
            have_nxt = 1'b1;
            star_nxt = p_r;
            mark_nxt = f_r;
            p_nxt    = p_r + 1'b1;
          end else if (is_hit) begin
            f_nxt = f_r + 1'b1;
            p_nxt = p_r + 1'b1;
          end else if (have_r) begin
            p_nxt    = star_r + 1'b1;
            mark_nxt = mark_r + 1'b1;
            f_nxt    = mark_r + 1'b1;
          end else begin
            done      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (is_star) begin
          p_nxt = p_r + 1'b1;
        end else begin
          done      = 1'b1;
          matched   = p_r == plen;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // present the next step's addresses so data lines up with p_r and f_r
  assign pat_raddr  = p_nxt[PAW-1:0];
  assign name_raddr = f_nxt[NAW-1:0];

  assign sts.busy     = state_r != ST_IDLE;
  assign sts.done     = done;
  assign sts.matched  = matched;
  assign sts.too_long = over_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    p_r    <= p_nxt;
    f_r    <= f_nxt;
    star_r <= star_nxt;
    mark_r <= mark_nxt;
    have_r <= have_nxt;
    nlen_r <= nlen_nxt;
    over_r <= over_nxt;
    fold_r <= fold_nxt;
  end

endmodule

/* rtl/wildcard_glob_match_unit.sv */
// ----------------------------------------------------------------------------
// Wildcard glob match unit
// Loads a pattern and a file name into two RAMs and matches them with
// '?' and '*' wildcards, optional ASCII case folding.
// ----------------------------------------------------------------------------
//  channel | ports                           | direction
//  --------+---------------------------------+----------
//  in      | in_valid/ready, op, ch, last    | input
//  out     | out_valid/ready, matched, too_long | output
//  cfg     | cfg_valid/ready, fold_case      | input
//
// Pattern and name characters are accepted one per cycle while no walk runs.
// An evaluation passes through a start state and then the walk; the walk steps through
// the pattern and name RAMs once per cycle, and backtracking to the last star
// sets the number of steps.
// Input stalls during the walk, and an evaluation stalls while a result waits.
// No clearing pass after reset; store data is only used below their lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_glob_match_unit #(
  parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF,
  parameter int NAME_MAX    = wgm_pkg::NAME_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  output logic       out_too_long,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_fold_case
);
  import wgm_pkg::*;

  localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int NAW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int PLW = $clog2(PATTERN_MAX + 1);
  localparam int NLW = $clog2(NAME_MAX + 1);
  localparam logic [PLW-1:0] PMAX = PLW'(PATTERN_MAX);
  localparam logic [NLW-1:0] NMAX = NLW'(NAME_MAX);

  op_t            op;
  logic           acc, is_eval;
  logic [PLW-1:0] plen_r, plen_nxt, pidx;
  logic [NLW-1:0] nlen_r, nlen_nxt, eval_nlen;
  logic           povf_r, povf_nxt, novf_r, novf_nxt, popen_r, popen_nxt;
  logic           eval_over;
  logic           fold_r;
  logic           out_valid_r, matched_r, too_long_r;
  logic           pat_we, name_we;
  logic [PAW-1:0] pat_raddr;
  logic [NAW-1:0] name_raddr;
  logic [7:0]     pat_rdata, name_rdata;
  walk_req_t      req;
  walk_sts_t      sts;

  assign op      = op_t'(in_op);
  assign is_eval = op == OP_EMPTY_NAME || (op == OP_NAME_CHAR && in_last);
  assign in_ready = !sts.busy && (!is_eval || !out_valid_r || out_ready);
  assign acc     = in_valid && in_ready;
  assign pidx    = popen_r ? plen_r : '0;

  always_comb begin
    plen_nxt  = plen_r;
    povf_nxt  = povf_r;
    popen_nxt = popen_r;
    nlen_nxt  = nlen_r;
    novf_nxt  = novf_r;
    pat_we    = 1'b0;
    name_we   = 1'b0;
    eval_nlen = '0;
    eval_over = povf_r;
    if (acc) begin
      unique case (op)
        OP_PAT_CHAR: begin
          if (!popen_r) begin
            plen_nxt = '0;
            povf_nxt = 1'b0;
          end
          if (pidx < PMAX) begin
            pat_we   = 1'b1;
            plen_nxt = pidx + 1'b1;
          end else begin
            povf_nxt = 1'b1;
          end
          popen_nxt = !in_last;
        end
        OP_NAME_CHAR: begin
          popen_nxt = 1'b0;
          if (nlen_r < NMAX) begin
            name_we   = 1'b1;
            eval_nlen = nlen_r + 1'b1;
            eval_over = povf_r || novf_r;
          end else begin
            eval_nlen = nlen_r;
            eval_over = 1'b1;
          end
          if (in_last) begin
            nlen_nxt = '0;
            novf_nxt = 1'b0;
          end else begin
            nlen_nxt = eval_nlen;
            novf_nxt = eval_over && !povf_r;
          end
        end
        OP_EMPTY_NAME: begin
          popen_nxt = 1'b0;
          nlen_nxt  = '0;
          novf_nxt  = 1'b0;
        end
        OP_EMPTY_PAT: begin
          plen_nxt  = '0;
          povf_nxt  = 1'b0;
          popen_nxt = 1'b0;
        end
        default: popen_nxt = popen_r;
      endcase
    end
  end

  assign req.start = acc && is_eval;
  assign req.over  = eval_over;
  assign req.fold  = fold_r;

  wgm_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX), .AW(PAW)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pidx[PAW-1:0]),
    .wdata (in_ch),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  wgm_ram #(.WIDTH(8), .DEPTH(NAME_MAX), .AW(NAW)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (nlen_r[NAW-1:0]),
    .wdata (in_ch),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  wgm_walk #(
    .PATTERN_MAX (PATTERN_MAX),
    .NAME_MAX    (NAME_MAX),
    .PAW         (PAW),
    .NAW         (NAW),
    .PLW         (PLW),
    .NLW         (NLW)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .plen       (plen_r),
    .nlen       (eval_nlen),
    .pat_rdata  (pat_rdata),
    .name_rdata (name_rdata),
    .pat_raddr  (pat_raddr),
    .name_raddr (name_raddr),
    .sts        (sts)
  );

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_matched  = matched_r;
  assign out_too_long = too_long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      povf_r      <= 1'b0;
      popen_r     <= 1'b0;
      nlen_r      <= '0;
      novf_r      <= 1'b0;
      fold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      plen_r  <= plen_nxt;
      povf_r  <= povf_nxt;
      popen_r <= popen_nxt;
      nlen_r  <= nlen_nxt;
      novf_r  <= novf_nxt;
      if (cfg_valid && cfg_ready) fold_r <= cfg_fold_case;
      if (sts.done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (sts.done) begin
      matched_r  <= sts.matched;
      too_long_r <= sts.too_long;
    end
  end

endmodule
